FILE: rtl/cyrillic_text_to_lcd_nibbles_core_defines.svh
// Assertion macros for the nibble converter RTL.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef CYRILLIC_TEXT_TO_LCD_NIBBLES_CORE_DEFINES_SVH
`define CYRILLIC_TEXT_TO_LCD_NIBBLES_CORE_DEFINES_SVH

// A property that must hold in every cycle out of reset.
`define CTL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define CTL_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ctlcd_pkg.sv
// Shared types, byte codes and the character ROM mapping for the converter.
// No dependencies.
package ctlcd_pkg;

  localparam logic [7:0] LEAD_D0 = 8'hD0;
  localparam logic [7:0] LEAD_D1 = 8'hD1;
  localparam logic [7:0] CONT_YO = 8'h91;
  localparam logic [7:0] CONT_ES = 8'h81;
  localparam logic [7:0] CODE_YO = 8'hF1;
  localparam logic [7:0] CODE_ES = 8'hF2;

  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_DEPTH = 2 ** FIFO_PTR_W;
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  // One byte waiting to be sent on the bus.
  typedef struct packed {
    logic [7:0] code;
    logic       rs;
  } entry_t;

  function automatic logic [7:0] rom_code(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h90: r = 8'h41;  8'h91: r = 8'hA0;  8'h92: r = 8'h42;
      8'h93: r = 8'hA1;  8'h94: r = 8'hE0;  8'h95: r = 8'h45;
      8'h81: r = 8'hA2;  8'h96: r = 8'hA3;  8'h97: r = 8'hA4;
      8'h98: r = 8'hA5;  8'h99: r = 8'hA6;  8'h9A: r = 8'h4B;
      8'h9B: r = 8'hA7;  8'h9C: r = 8'h4D;  8'h9D: r = 8'h48;
      8'h9E: r = 8'h4F;  8'h9F: r = 8'hA8;  8'hA0: r = 8'h50;
      8'hA1: r = 8'h43;  8'hA2: r = 8'h54;  8'hA3: r = 8'hA9;
      8'hA4: r = 8'hAA;  8'hA5: r = 8'h58;  8'hA6: r = 8'hE1;
      8'hA7: r = 8'hAB;  8'hA8: r = 8'hAC;  8'hA9: r = 8'hE2;
      8'hAA: r = 8'hAD;  8'hAB: r = 8'hAE;  8'hAC: r = 8'hC4;
      8'hAD: r = 8'hAF;  8'hAE: r = 8'hB0;  8'hAF: r = 8'hB1;
      8'hB0: r = 8'h61;  8'hB1: r = 8'hB2;  8'hB2: r = 8'hB3;
      8'hB3: r = 8'hB4;  8'hB4: r = 8'h67;  8'hB5: r = 8'h65;
      8'hBE: r = 8'h6F;  8'hBF: r = 8'hBE;
      8'hF1: r = 8'hB5;  8'h80: r = 8'h70;  8'hF2: r = 8'h63;
      8'h82: r = 8'hBF;  8'h83: r = 8'h79;  8'h84: r = 8'hE4;
      8'h85: r = 8'h78;  8'h86: r = 8'hE5;  8'h87: r = 8'hC0;
      8'h88: r = 8'hC1;  8'h89: r = 8'hE6;  8'h8A: r = 8'hC2;
      8'h8B: r = 8'hC3;  8'h8C: r = 8'hC4;  8'h8D: r = 8'hC5;
      8'h8E: r = 8'hC6;  8'h8F: r = 8'hC7;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ctlcd_front.sv
// Front end: accepts input bytes, tracks the 0xD1 lead byte and transcodes text.
// Depends on ctlcd_pkg.
module ctlcd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [7:0]        code_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output ctlcd_pkg::entry_t push_entry_o
);
  import ctlcd_pkg::*;

  logic       lead_q, lead_d;
  logic       accept;
  logic       is_lead;
  logic [7:0] remap;
  logic [7:0] mapped;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_lead    = (code_byte_i == LEAD_D0) || (code_byte_i == LEAD_D1);

  always_comb begin
    remap = code_byte_i;
    if (lead_q && code_byte_i == CONT_YO) begin
      remap = CODE_YO;
    end else if (lead_q && code_byte_i == CONT_ES) begin
      remap = CODE_ES;
    end
    mapped = rom_code(remap);
  end

  always_comb begin
    lead_d = lead_q;
    if (accept && !action_i) begin
      if (code_byte_i == LEAD_D1) begin
        lead_d = 1'b1;
      end else if (code_byte_i != LEAD_D0) begin
        lead_d = 1'b0;
      end
    end
  end

  // Lead bytes and text that maps to zero are absorbed here.
  assign push_o = accept && (action_i || (!is_lead && mapped != 8'h00));
  assign push_entry_o.code = action_i ? code_byte_i : mapped;
  assign push_entry_o.rs   = !action_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 1'b0;
    end else begin
      lead_q <= lead_d;
    end
  end

endmodule

FILE: rtl/ctlcd_fifo.sv
// Short queue of bytes between the front end and the nibble sequencer.
// Depends on ctlcd_pkg.
module ctlcd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ctlcd_pkg::entry_t push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ctlcd_pkg::entry_t head_o
);
  import ctlcd_pkg::*;

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/ctlcd_back.sv
// Back end: sends each queued byte as two nibble transfers, high nibble first.
// Depends on ctlcd_pkg and the assertion macro header.
`include "cyrillic_text_to_lcd_nibbles_core_defines.svh"
module ctlcd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ctlcd_pkg::entry_t q_head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        nibble_o,
  output logic              rs_o,
  output logic              last_o
);
  import ctlcd_pkg::*;

  logic       valid_q, valid_d;
  logic       low_q, low_d;
  logic [7:0] code_q, code_d;
  logic       rs_q, rs_d;
  logic       xfer;

  assign xfer  = valid_q && out_ready_i;
  // A new byte is loaded when the register is empty or its low nibble leaves.
  assign pop_o = q_valid_i && (!valid_q || (xfer && low_q));

  always_comb begin
    valid_d = valid_q;
    low_d   = low_q;
    code_d  = code_q;
    rs_d    = rs_q;
    if (pop_o) begin
      valid_d = 1'b1;
      low_d   = 1'b0;
      code_d  = q_head_i.code;
      rs_d    = q_head_i.rs;
    end else if (xfer) begin
      if (low_q) begin
        valid_d = 1'b0;
      end else begin
        low_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      low_q   <= 1'b0;
      code_q  <= '0;
      rs_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      low_q   <= low_d;
      code_q  <= code_d;
      rs_q    <= rs_d;
    end
  end

  assign out_valid_o = valid_q;
  assign nibble_o    = low_q ? code_q[3:0] : code_q[7:4];
  assign rs_o        = rs_q;
  assign last_o      = low_q;

  `CTL_ASSERT_NEXT(a_high_then_low, xfer && !low_q, valid_q && low_q,
                   "high nibble was not followed by its low nibble")
  `CTL_ASSERT_NEXT(a_byte_held, xfer && !low_q, code_q == $past(code_q) && rs_q == $past(rs_q),
                   "byte changed between its two nibbles")
  `CTL_ASSERT_NEXT(a_drain_empty, xfer && low_q && !q_valid_i, !valid_q,
                   "output stayed valid with nothing queued")

endmodule

FILE: rtl/cyrillic_text_to_lcd_nibbles_core.sv
// Top level of the UTF-8 Cyrillic to 4-bit character display converter.
// Depends on ctlcd_pkg, ctlcd_front, ctlcd_fifo and ctlcd_back.
//
//   Channel   Dir   tdata             tuser              tlast
//   s_axis    in    code_byte[7:0]    action             -
//   m_axis    out   nibble[3:0]       register_select    last
//
// Each sent byte leaves as two nibble transfers, high nibble first, so the
// nibble sequencer sets the pace at which bytes may be accepted.
// Lead bytes and dropped text are accepted but give no transfer.
// A two-entry queue parts the front end from the sequencer; input stalls
// only when it is full. Reset is asynchronous, active low, and clears the
// lead flag, the queue and the output valid.
module cyrillic_text_to_lcd_nibbles_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] code_byte
  input  logic       s_axis_tuser,  // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [3:0] nibble, [7:4] zero
  output logic       m_axis_tuser,  // [0] register_select
  output logic       m_axis_tlast
);
  import ctlcd_pkg::*;

  logic       q_full;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  logic       q_valid;
  entry_t     q_head;
  logic [3:0] nibble;

  ctlcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tuser),
    .code_byte_i  (s_axis_tdata),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  ctlcd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  ctlcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .nibble_o    (nibble),
    .rs_o        (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, nibble};

endmodule
